### design/stc_pkg.sv
`timescale 1ns / 1ps
// Package for the sensor temperature compensation block: field widths,
// arithmetic constants, register codes and the structs passed between stages.
// No dependencies.
package stc_pkg;

  localparam int RAW_W    = 16;
  localparam int CAL_W    = 16;
  localparam int DIFF_W   = 17;
  localparam int PROD_W   = 34;
  localparam int X1_W     = 18;
  localparam int DIVS_W   = 19;
  localparam int DEN_W    = 18;
  localparam int NUM_W    = 27;
  localparam int SUM_W    = 28;
  localparam int TEMP_W   = 24;
  localparam int T9_W     = 27;
  localparam int MAG9_W   = 26;
  localparam int RECIP_W  = 27;
  localparam int RMUL_W   = 53;

  localparam int X1_SHIFT    = 15;
  localparam int NUM_SHIFT   = 11;
  localparam int T_SHIFT     = 4;
  localparam int T9_SHIFT    = 3;
  localparam int RECIP_SHIFT = 29;

  localparam logic [PROD_W-1:0]  X1_ROUND   = PROD_W'(32767);
  localparam logic [SUM_W-1:0]   T_BIAS     = SUM_W'(8);
  localparam logic [SUM_W-1:0]   T_ROUND    = SUM_W'(15);
  localparam logic [RECIP_W-1:0] RECIP_FIVE = RECIP_W'(107374183);
  localparam logic [TEMP_W-1:0]  F_OFFSET   = TEMP_W'(320);

  localparam int DIV_BITS_DEFAULT = 3;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    REG_AC5 = 2'd0,
    REG_AC6 = 2'd1,
    REG_MC  = 2'd2,
    REG_MD  = 2'd3
  } stc_reg_t;

  typedef struct packed {
    logic [CAL_W-1:0] ac5;
    logic [CAL_W-1:0] ac6;
    logic [CAL_W-1:0] mc;
    logic [CAL_W-1:0] md;
  } stc_cal_t;

  typedef struct packed {
    logic [X1_W-1:0] x1;
    logic            q_neg;
    logic            dbz;
  } stc_side_t;

  typedef struct packed {
    stc_side_t        side;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } stc_dreq_t;

  typedef struct packed {
    stc_side_t        side;
    logic [NUM_W-1:0] quot;
  } stc_dres_t;

endpackage

### design/stc_front.sv
`timescale 1ns / 1ps
// Front stages: raw offset, slope multiply, scaling to x1 and forming the
// signed divisor and dividend magnitudes. Depends on stc_pkg.
module stc_front
  import stc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  stc_cal_t          cal,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [RAW_W-1:0]  in_raw_temp,
  output logic              out_valid,
  input  logic              out_stall,
  output stc_dreq_t         out_req
);

  localparam int NS = 5;

  logic [NS-1:0] valid_r;
  logic [NS:0]   rdy;
  logic [NS:0]   vin;

  logic signed [DIFF_W-1:0] diff_r;
  logic signed [DIFF_W-1:0] diff_nxt;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [PROD_W-1:0] prod_adj;
  logic signed [X1_W-1:0]   x1_r;
  logic signed [X1_W-1:0]   x1_nxt;
  logic signed [X1_W-1:0]   x1_d_r;
  logic signed [DIVS_W-1:0] div_r;
  logic signed [DIVS_W-1:0] div_nxt;
  logic [CAL_W:0]           mc_ext;
  logic [CAL_W:0]           mc_mag;
  logic [DEN_W-1:0]         den_r;
  logic [DEN_W-1:0]         den_nxt;
  logic [NUM_W-1:0]         num_r;
  logic [NUM_W-1:0]         num_nxt;
  logic [X1_W-1:0]          x1_o_r;
  logic                     qneg_r;
  logic                     dbz_r;

  assign rdy[NS] = !out_stall;
  genvar gk;
  for (gk = 0; gk < NS; gk++) begin : g_rdy
    assign rdy[gk] = !valid_r[gk] || rdy[gk+1];
  end
  assign vin      = {valid_r, in_valid};
  assign in_stall = !rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) begin
          valid_r[k] <= vin[k];
        end
      end
    end
  end

  always_comb begin
    diff_nxt = $signed({1'b0, in_raw_temp}) - $signed({1'b0, cal.ac6});
    prod_nxt = PROD_W'(diff_r) * PROD_W'($signed({1'b0, cal.ac5}));
    prod_adj = prod_r + (prod_r[PROD_W-1] ? X1_ROUND : '0);
    x1_nxt   = X1_W'(prod_adj >>> X1_SHIFT);
    div_nxt  = DIVS_W'(x1_r) + DIVS_W'($signed(cal.md));
    mc_ext   = {cal.mc[CAL_W-1], cal.mc};
    mc_mag   = cal.mc[CAL_W-1] ? -mc_ext : mc_ext;
    num_nxt  = NUM_W'(mc_mag) << NUM_SHIFT;
    den_nxt  = div_r[DIVS_W-1] ? DEN_W'(-div_r) : DEN_W'(div_r);
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      diff_r <= diff_nxt;
    end
    if (rdy[1]) begin
      prod_r <= prod_nxt;
    end
    if (rdy[2]) begin
      x1_r <= x1_nxt;
    end
    if (rdy[3]) begin
      div_r  <= div_nxt;
      x1_d_r <= x1_r;
    end
    if (rdy[4]) begin
      den_r  <= den_nxt;
      num_r  <= num_nxt;
      x1_o_r <= x1_d_r;
      qneg_r <= div_r[DIVS_W-1] ^ cal.mc[CAL_W-1];
      dbz_r  <= (div_r == '0);
    end
  end

  assign out_valid          = valid_r[NS-1];
  assign out_req.side.x1    = x1_o_r;
  assign out_req.side.q_neg = qneg_r;
  assign out_req.side.dbz   = dbz_r;
  assign out_req.num        = num_r;
  assign out_req.den        = den_r;

endmodule

### design/stc_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider on magnitudes, DIV_BITS quotient bits per
// stage, with the side fields carried alongside. Depends on stc_pkg.
module stc_div
  import stc_pkg::*;
#(
  parameter int DIV_BITS = DIV_BITS_DEFAULT
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  stc_dreq_t in_req,
  output logic      out_valid,
  input  logic      out_stall,
  output stc_dres_t out_res
);

  localparam int NSTG  = (NUM_W + DIV_BITS - 1) / DIV_BITS;
  localparam int PAD_W = NSTG * DIV_BITS;

  logic [NSTG-1:0]  valid_r;
  logic [NSTG:0]    rdy;
  logic [NSTG:0]    vin;

  logic [DEN_W-1:0] rem_r  [NSTG];
  logic [PAD_W-1:0] nq_r   [NSTG];
  logic [DEN_W-1:0] den_r  [NSTG];
  stc_side_t        side_r [NSTG];

  logic [DEN_W-1:0] rem_s  [NSTG+1];
  logic [PAD_W-1:0] nq_s   [NSTG+1];
  logic [DEN_W-1:0] den_s  [NSTG+1];
  stc_side_t        side_s [NSTG+1];

  logic [DEN_W-1:0] rem_nxt [NSTG];
  logic [PAD_W-1:0] nq_nxt  [NSTG];

  assign rdy[NSTG] = !out_stall;
  genvar gk;
  for (gk = 0; gk < NSTG; gk++) begin : g_rdy
    assign rdy[gk] = !valid_r[gk] || rdy[gk+1];
  end
  assign vin      = {valid_r, in_valid};
  assign in_stall = !rdy[0];

  always_comb begin
    rem_s[0]  = '0;
    nq_s[0]   = PAD_W'(in_req.num);
    den_s[0]  = in_req.den;
    side_s[0] = in_req.side;
    for (int k = 0; k < NSTG; k++) begin
      rem_s[k+1]  = rem_r[k];
      nq_s[k+1]   = nq_r[k];
      den_s[k+1]  = den_r[k];
      side_s[k+1] = side_r[k];
    end
  end

  always_comb begin : step
    logic [DEN_W:0]   trial;
    logic [DEN_W-1:0] rem_v;
    logic [PAD_W-1:0] nq_v;
    for (int k = 0; k < NSTG; k++) begin
      rem_v = rem_s[k];
      nq_v  = nq_s[k];
      for (int b = 0; b < DIV_BITS; b++) begin
        trial = {rem_v, nq_v[PAD_W-1]};
        nq_v  = {nq_v[PAD_W-2:0], 1'b0};
        if (trial >= {1'b0, den_s[k]}) begin
          trial   = trial - {1'b0, den_s[k]};
          nq_v[0] = 1'b1;
        end
        rem_v = trial[DEN_W-1:0];
      end
      rem_nxt[k] = rem_v;
      nq_nxt[k]  = nq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (rdy[k]) begin
          valid_r[k] <= vin[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NSTG; k++) begin
      if (rdy[k]) begin
        rem_r[k]  <= rem_nxt[k];
        nq_r[k]   <= nq_nxt[k];
        den_r[k]  <= den_s[k];
        side_r[k] <= side_s[k];
      end
    end
  end

  assign out_valid    = valid_r[NSTG-1];
  assign out_res.side = side_r[NSTG-1];
  assign out_res.quot = nq_r[NSTG-1][NUM_W-1:0];

endmodule

### design/stc_back.sv
`timescale 1ns / 1ps
// Back stages: signed x2, Celsius sum and scaling, Fahrenheit conversion by
// reciprocal multiply, and the output register. Depends on stc_pkg.
module stc_back
  import stc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  stc_dres_t         in_res,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [TEMP_W-1:0] out_celsius,
  output logic [TEMP_W-1:0] out_fahrenheit,
  output logic              out_dbz
);

  localparam int NS = 8;

  logic [NS-1:0] valid_r;
  logic [NS:0]   rdy;
  logic [NS:0]   vin;

  logic signed [X1_W-1:0]   x1_0_r;
  logic signed [SUM_W-1:0]  x2_0_r;
  logic signed [SUM_W-1:0]  x2_nxt;
  logic signed [SUM_W-1:0]  sum_1_r;
  logic signed [SUM_W-1:0]  sum_nxt;
  logic signed [SUM_W-1:0]  sum_adj;
  logic signed [TEMP_W-1:0] t_2_r;
  logic signed [TEMP_W-1:0] t_nxt;
  logic signed [T9_W-1:0]   t9_3_r;
  logic signed [T9_W-1:0]   t9_nxt;
  logic [MAG9_W-1:0]        mag_4_r;
  logic [MAG9_W-1:0]        mag_nxt;
  logic [RMUL_W-1:0]        rprod_5_r;
  logic [RMUL_W-1:0]        rprod_nxt;
  logic [TEMP_W-1:0]        qmag;
  logic [TEMP_W-1:0]        q_6_r;
  logic [TEMP_W-1:0]        q_nxt;
  logic [TEMP_W-1:0]        f_7_r;
  logic [TEMP_W-1:0]        t_3_r;
  logic [TEMP_W-1:0]        t_4_r;
  logic [TEMP_W-1:0]        t_5_r;
  logic [TEMP_W-1:0]        t_6_r;
  logic [TEMP_W-1:0]        t_7_r;
  logic                     neg_4_r;
  logic                     neg_5_r;
  logic [NS-1:0]            dbz_r;

  assign rdy[NS] = !out_stall;
  genvar gk;
  for (gk = 0; gk < NS; gk++) begin : g_rdy
    assign rdy[gk] = !valid_r[gk] || rdy[gk+1];
  end
  assign vin      = {valid_r, in_valid};
  assign in_stall = !rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) begin
          valid_r[k] <= vin[k];
        end
      end
    end
  end

  always_comb begin
    if (in_res.side.dbz) begin
      x2_nxt = '0;
    end else if (in_res.side.q_neg) begin
      x2_nxt = -SUM_W'(in_res.quot);
    end else begin
      x2_nxt = SUM_W'(in_res.quot);
    end
    sum_nxt   = SUM_W'(x1_0_r) + x2_0_r + T_BIAS;
    sum_adj   = sum_1_r + (sum_1_r[SUM_W-1] ? T_ROUND : '0);
    t_nxt     = TEMP_W'(sum_adj >>> T_SHIFT);
    t9_nxt    = (T9_W'(t_2_r) <<< T9_SHIFT) + T9_W'(t_2_r);
    mag_nxt   = t9_3_r[T9_W-1] ? MAG9_W'(-t9_3_r) : MAG9_W'(t9_3_r);
    rprod_nxt = RMUL_W'(mag_4_r) * RMUL_W'(RECIP_FIVE);
    qmag      = TEMP_W'(rprod_5_r >> RECIP_SHIFT);
    q_nxt     = neg_5_r ? -qmag : qmag;
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      x1_0_r   <= $signed(in_res.side.x1);
      x2_0_r   <= x2_nxt;
      dbz_r[0] <= in_res.side.dbz;
    end
    if (rdy[1]) begin
      sum_1_r  <= sum_nxt;
      dbz_r[1] <= dbz_r[0];
    end
    if (rdy[2]) begin
      t_2_r    <= t_nxt;
      dbz_r[2] <= dbz_r[1];
    end
    if (rdy[3]) begin
      t9_3_r   <= t9_nxt;
      t_3_r    <= t_2_r;
      dbz_r[3] <= dbz_r[2];
    end
    if (rdy[4]) begin
      mag_4_r  <= mag_nxt;
      neg_4_r  <= t9_3_r[T9_W-1];
      t_4_r    <= t_3_r;
      dbz_r[4] <= dbz_r[3];
    end
    if (rdy[5]) begin
      rprod_5_r <= rprod_nxt;
      neg_5_r   <= neg_4_r;
      t_5_r     <= t_4_r;
      dbz_r[5]  <= dbz_r[4];
    end
    if (rdy[6]) begin
      q_6_r    <= q_nxt;
      t_6_r    <= t_5_r;
      dbz_r[6] <= dbz_r[5];
    end
    if (rdy[7]) begin
      f_7_r    <= q_6_r + F_OFFSET;
      t_7_r    <= t_6_r;
      dbz_r[7] <= dbz_r[6];
    end
  end

  assign out_valid      = valid_r[NS-1];
  assign out_celsius    = t_7_r;
  assign out_fahrenheit = f_7_r;
  assign out_dbz        = dbz_r[NS-1];

endmodule

### design/sensor_temperature_compensation.sv
`timescale 1ns / 1ps
// Top level of the temperature compensation pipeline: calibration registers
// on the APB-style port, and stc_front, stc_div and stc_back. Depends on stc_pkg.
//
//   Channel  Direction  Handshake                  Payload
//   in_      input      in_valid / in_stall        in_raw_temp
//   out_     output     out_valid / out_stall      celsius, fahrenheit, divide flag
//   cfg      input      psel, penable, pwrite      paddr, pwdata, prdata
//
// One transfer enters per cycle while in_stall is low; each passes in turn through the
// front stages, the divider stages and the back stages to the output register.
// Reset clears the valid bits of every stage and the calibration words.
// A stall at the output stops only the stages that are full; bubbles close up,
// so the input takes transfers until every stage holds one.
module sensor_temperature_compensation
  import stc_pkg::*;
#(
  parameter int DIV_BITS = DIV_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [RAW_W-1:0]  in_raw_temp,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [TEMP_W-1:0] out_celsius_tenths,
  output logic [TEMP_W-1:0] out_fahrenheit_tenths,
  output logic              out_divide_by_zero,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  stc_cal_t  cal_r;
  stc_reg_t  reg_sel;
  logic      cfg_wr;

  logic      f_valid;
  logic      f_stall;
  stc_dreq_t f_req;
  logic      d_valid;
  logic      d_stall;
  stc_dres_t d_res;

  assign pready  = 1'b1;
  assign reg_sel = stc_reg_t'(paddr[ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= '0;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_AC5: cal_r.ac5 <= pwdata[CAL_W-1:0];
        REG_AC6: cal_r.ac6 <= pwdata[CAL_W-1:0];
        REG_MC:  cal_r.mc  <= pwdata[CAL_W-1:0];
        REG_MD:  cal_r.md  <= pwdata[CAL_W-1:0];
        default: cal_r     <= cal_r;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_AC5: prdata = DATA_W'(cal_r.ac5);
      REG_AC6: prdata = DATA_W'(cal_r.ac6);
      REG_MC:  prdata = DATA_W'(cal_r.mc);
      REG_MD:  prdata = DATA_W'(cal_r.md);
      default: prdata = '0;
    endcase
  end

  stc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cal         (cal_r),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_raw_temp (in_raw_temp),
    .out_valid   (f_valid),
    .out_stall   (f_stall),
    .out_req     (f_req)
  );

  stc_div #(
    .DIV_BITS (DIV_BITS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_valid),
    .in_stall  (f_stall),
    .in_req    (f_req),
    .out_valid (d_valid),
    .out_stall (d_stall),
    .out_res   (d_res)
  );

  stc_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (d_valid),
    .in_stall       (d_stall),
    .in_res         (d_res),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_celsius    (out_celsius_tenths),
    .out_fahrenheit (out_fahrenheit_tenths),
    .out_dbz        (out_divide_by_zero)
  );

endmodule

### design/stc_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the temperature compensation top level, bound to it
// below. Depends on stc_pkg.
module stc_checker
  import stc_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [TEMP_W-1:0] out_celsius_tenths,
  input logic [TEMP_W-1:0] out_fahrenheit_tenths,
  input logic              out_divide_by_zero
);

  // The input can only be held off when the whole pipeline is backed up.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while the output was free");

  a_stall_keeps_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> out_valid)
    else $error("result lost after an input stall");

  a_out_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_out_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> ($stable(out_celsius_tenths)
      && $stable(out_fahrenheit_tenths) && $stable(out_divide_by_zero)))
    else $error("output transfer changed while stalled");

endmodule

bind sensor_temperature_compensation stc_checker u_stc_checker (.*);

### bench/stc_result_checker.sv
`timescale 1ns / 1ps
// Result checker for sensor_temperature_compensation: follows the calibration writes,
// predicts the compensated reading for every input transfer and compares each output
// transfer with the oldest prediction. Depends on stc_pkg.
module stc_result_checker
  import stc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [RAW_W-1:0]  in_raw_temp,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [TEMP_W-1:0] out_celsius_tenths,
  input  logic [TEMP_W-1:0] out_fahrenheit_tenths,
  input  logic              out_divide_by_zero,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output int                mismatches,
  output int                awaiting,
  output int                results_checked,
  output int                zero_divisors
);

  typedef struct packed {
    logic [RAW_W-1:0]  raw;
    logic [TEMP_W-1:0] celsius;
    logic [TEMP_W-1:0] fahrenheit;
    logic              dbz;
  } temp_reading_t;

  stc_cal_t      cal;
  temp_reading_t expected_readings[$];

  function automatic temp_reading_t compensate_reading(logic [RAW_W-1:0] raw, stc_cal_t c);
    longint        x1;
    longint        divisor;
    longint        x2;
    longint        t;
    longint        f;
    temp_reading_t r;
    x1 = ((longint'(raw) - longint'(c.ac6)) * longint'(c.ac5)) / 32768;
    divisor = x1 + longint'($signed(c.md));
    if (divisor == 0) begin
      x2 = 0;
      r.dbz = 1'b1;
    end else begin
      x2 = (longint'($signed(c.mc)) * 2048) / divisor;
      r.dbz = 1'b0;
    end
    t = (x1 + x2 + 8) / 16;
    f = (t * 9) / 5 + 320;
    r.raw = raw;
    r.celsius = t[TEMP_W-1:0];
    r.fahrenheit = f[TEMP_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    temp_reading_t want;
    if (!rst_n) begin
      cal <= '0;
      expected_readings.delete();
      mismatches <= 0;
      awaiting <= 0;
      results_checked <= 0;
      zero_divisors <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (stc_reg_t'(paddr[ADDR_W-1:2]))
          REG_AC5: cal.ac5 <= pwdata[CAL_W-1:0];
          REG_AC6: cal.ac6 <= pwdata[CAL_W-1:0];
          REG_MC:  cal.mc  <= pwdata[CAL_W-1:0];
          REG_MD:  cal.md  <= pwdata[CAL_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        results_checked <= results_checked + 1;
        if (expected_readings.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("Unexpected output transfer: C=%0d F=%0d dbz=%0b",
                     $signed(out_celsius_tenths), $signed(out_fahrenheit_tenths),
                     out_divide_by_zero);
        end else begin
          want = expected_readings.pop_front();
          zero_divisors <= zero_divisors + int'(want.dbz);
          if (out_celsius_tenths !== want.celsius ||
              out_fahrenheit_tenths !== want.fahrenheit ||
              out_divide_by_zero !== want.dbz) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("Mismatch for raw %0d: expected C=%0d F=%0d dbz=%0b, got C=%0d F=%0d dbz=%0b",
                       want.raw, $signed(want.celsius), $signed(want.fahrenheit), want.dbz,
                       $signed(out_celsius_tenths), $signed(out_fahrenheit_tenths),
                       out_divide_by_zero);
          end
        end
      end
      if (in_valid && !in_stall)
        expected_readings.push_back(compensate_reading(in_raw_temp, cal));
      awaiting <= expected_readings.size();
    end
  end

endmodule

### bench/sensor_temperature_compensation_test.sv
`timescale 1ns / 1ps
// Top of the testbench for sensor_temperature_compensation: clock, reset, calibration
// writes, raw readings and output stalls, with the verdict from stc_result_checker.
// Depends on stc_pkg, the block and the checker.
module sensor_temperature_compensation_test;
  import stc_pkg::*;

  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 230;
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_CYCLES  = 40;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [RAW_W-1:0]  in_raw_temp;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [TEMP_W-1:0] out_celsius_tenths;
  logic [TEMP_W-1:0] out_fahrenheit_tenths;
  logic              out_divide_by_zero;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int mismatches;
  int awaiting;
  int results_checked;
  int zero_divisors;

  bit               tx_idle_on;
  bit               rx_idle_on;
  bit               hold_req;
  int               rx_stall_left;
  int               readings_sent;
  int               settings_used;
  logic [CAL_W-1:0] cur_ac5;
  logic [CAL_W-1:0] cur_ac6;
  logic [CAL_W-1:0] cur_md;

  sensor_temperature_compensation u_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_raw_temp           (in_raw_temp),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_celsius_tenths    (out_celsius_tenths),
    .out_fahrenheit_tenths (out_fahrenheit_tenths),
    .out_divide_by_zero    (out_divide_by_zero),
    .psel                  (psel),
    .penable               (penable),
    .pwrite                (pwrite),
    .paddr                 (paddr),
    .pwdata                (pwdata),
    .prdata                (prdata),
    .pready                (pready)
  );

  stc_result_checker u_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_raw_temp           (in_raw_temp),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_celsius_tenths    (out_celsius_tenths),
    .out_fahrenheit_tenths (out_fahrenheit_tenths),
    .out_divide_by_zero    (out_divide_by_zero),
    .psel                  (psel),
    .penable               (penable),
    .pwrite                (pwrite),
    .pready                (pready),
    .paddr                 (paddr),
    .pwdata                (pwdata),
    .mismatches            (mismatches),
    .awaiting              (awaiting),
    .results_checked       (results_checked),
    .zero_divisors         (zero_divisors)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_stall_left = 0;
    end else if (rx_stall_left > 0) begin
      out_stall <= 1'b1;
      rx_stall_left = rx_stall_left - 1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      rx_stall_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
      rx_stall_left = $urandom_range(0, 11);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_reading(logic [RAW_W-1:0] raw);
    in_valid <= 1'b1;
    in_raw_temp <= raw;
    do @(posedge clk); while (in_stall);
    readings_sent++;
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      in_raw_temp <= RAW_W'($urandom);
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaiting != 0);
  endtask

  task automatic write_cal_reg(stc_reg_t idx, logic [CAL_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {(DATA_W - CAL_W)'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_calibration(logic [CAL_W-1:0] ac5, logic [CAL_W-1:0] ac6,
                                 logic [CAL_W-1:0] mc, logic [CAL_W-1:0] md);
    write_cal_reg(REG_AC5, ac5);
    write_cal_reg(REG_AC6, ac6);
    write_cal_reg(REG_MC, mc);
    write_cal_reg(REG_MD, md);
    cur_ac5 = ac5;
    cur_ac6 = ac6;
    cur_md = md;
    settings_used++;
  endtask

  // Mostly uniform words, plus the field edges, words close to the offset, and
  // words that make the divisor zero when the slope is exactly one.
  function automatic logic [RAW_W-1:0] pick_raw();
    int r;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: r = 0;
          1: r = 65535;
          2: r = 32768;
          default: r = 32767;
        endcase
      end
      1: r = int'(cur_ac6) + int'($urandom_range(0, 128)) - 64;
      2: begin
        if (cur_ac5 == 16'h8000)
          r = int'(cur_ac6) - int'($signed(cur_md));
        else
          r = $urandom_range(0, 65535);
      end
      default: r = $urandom_range(0, 65535);
    endcase
    if (r < 0 || r > 65535)
      r = $urandom_range(0, 65535);
    return RAW_W'(r);
  endfunction

  initial begin
    int  a5;
    int  a6;
    int  c;
    int  d;
    bit  last;
    in_valid <= 1'b0;
    in_raw_temp <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    rst_n <= 1'b0;
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    hold_req = 1'b0;
    readings_sent = 0;
    settings_used = 1;
    cur_ac5 = '0;
    cur_ac6 = '0;
    cur_md = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    send_reading(16'h0000);
    send_reading(16'hFFFF);
    wait_drained();
    set_calibration(16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF);
    send_reading(16'h0000);
    send_reading(16'h0001);
    send_reading(16'h8000);
    send_reading(16'hFFFF);
    wait_drained();
    set_calibration(16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h8000);
    send_reading(16'h0000);
    send_reading(16'h7FFF);
    send_reading(16'hFFFF);
    wait_drained();
    set_calibration(16'h8000, CAL_W'(1000), CAL_W'(-11075), CAL_W'(-500));
    send_reading(RAW_W'(1500));
    send_reading(RAW_W'(1499));
    send_reading(RAW_W'(1501));
    send_reading(16'h0000);
    send_reading(16'hFFFF);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_drained();
      case (p % 4)
        0: begin
          a5 = $urandom_range(24000, 34000);
          a6 = $urandom_range(15000, 25000);
          c = -int'($urandom_range(8000, 12000));
          d = $urandom_range(2000, 3500);
        end
        1: begin
          a5 = $urandom_range(0, 65535);
          a6 = $urandom_range(0, 65535);
          c = $urandom_range(0, 65535);
          d = $urandom_range(0, 65535);
        end
        2: begin
          a5 = 32768;
          a6 = $urandom_range(0, 65535);
          c = $urandom_range(0, 65535);
          d = int'($urandom_range(0, 4000)) - 2000;
        end
        default: begin
          a5 = ($urandom_range(0, 1) != 0) ? 65535 : $urandom_range(0, 1);
          a6 = ($urandom_range(0, 1) != 0) ? 65535 : 0;
          c = ($urandom_range(0, 1) != 0) ? -32768 : 32767;
          d = ($urandom_range(0, 1) != 0) ? -32768 : 32767;
        end
      endcase
      set_calibration(CAL_W'(a5), CAL_W'(a6), CAL_W'(c), CAL_W'(d));
      last = (p == RANDOM_PHASES - 1);
      tx_idle_on = !last;
      rx_idle_on = !last;
      if (p == 1) begin
        hold_req = 1'b1;
        tx_idle_on = 1'b0;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (!last && i % 40 == 0 && !(p == 1 && i < 80)) begin
          tx_idle_on = $urandom_range(0, 3) != 0;
          rx_idle_on = $urandom_range(0, 3) != 0;
        end
        if (p == 3 && i == PHASE_ITEMS / 2)
          wait_drained();
        send_reading(pick_raw());
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d raw readings under %0d calibration settings; %0d results compared,",
             readings_sent, settings_used, results_checked);
    $display("%0d of them with a zero divisor, with a long output hold and idle bursts.",
             zero_divisors);
    if (mismatches == 0 && awaiting == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Run did not finish in time.");
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
